### design/khm_pkg.sv
`default_nettype none

package khm_pkg;

   localparam int CAPACITY_DEFAULT = 64;
   localparam int MAX_RUNS_DEFAULT = 8;

   localparam int VALUE_W      = 32;
   localparam int RUN_COUNT_W  = 4;
   localparam int RUN_LENGTH_W = 7;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 7;

   localparam logic [CSR_INDEX_W-1:0] CSR_RUN_COUNT  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RUN_LENGTH = 1'd1;

   localparam logic [RUN_COUNT_W-1:0]  RUN_COUNT_RESET  = 4'd1;
   localparam logic [RUN_LENGTH_W-1:0] RUN_LENGTH_RESET = 7'd64;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_CLEAR,
      OP_INSERT,
      OP_REPLACE
   } op_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_BUILD,
      ST_EMIT,
      ST_FILL
   } state_type;

endpackage

`default_nettype wire

### design/khm_store.sv
`default_nettype none

module khm_store import khm_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEFAULT,
   localparam int AW = $clog2(CAPACITY)
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [AW-1:0]             wr_addr,
   input  wire logic signed [VALUE_W-1:0] wr_data,
   input  wire logic [AW-1:0]             rd_addr,
   output logic signed [VALUE_W-1:0]      rd_data
);

   logic signed [VALUE_W-1:0] mem [CAPACITY];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

### design/khm_cell.sv
`default_nettype none

module khm_cell import khm_pkg::*; #(
   parameter int TAG_WIDTH = 2 * $clog2(CAPACITY_DEFAULT + 1)
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire op_type                    op,
   input  wire logic                      head,
   input  wire logic                      x_valid,
   input  wire logic signed [VALUE_W-1:0] x_value,
   input  wire logic [TAG_WIDTH-1:0]      x_tag,
   input  wire logic                      left_valid,
   input  wire logic signed [VALUE_W-1:0] left_value,
   input  wire logic [TAG_WIDTH-1:0]      left_tag,
   input  wire logic                      left_le,
   input  wire logic                      right_valid,
   input  wire logic signed [VALUE_W-1:0] right_value,
   input  wire logic [TAG_WIDTH-1:0]      right_tag,
   input  wire logic                      right_le,
   output logic                           valid,
   output logic signed [VALUE_W-1:0]      value,
   output logic [TAG_WIDTH-1:0]           tag,
   output logic                           le
);

   logic                      valid_ff, valid_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic [TAG_WIDTH-1:0]      tag_ff, tag_in;

   // An empty entry ranks above every valid value.
   assign le = valid_ff && (!x_valid || (value_ff <= x_value));

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      tag_in   = tag_ff;
      case (op)
         OP_CLEAR: begin
            valid_in = 1'b0;
         end
         OP_INSERT: begin
            if (!le) begin
               if (left_le) begin
                  valid_in = x_valid;
                  value_in = x_value;
                  tag_in   = x_tag;
               end else begin
                  valid_in = left_valid;
                  value_in = left_value;
                  tag_in   = left_tag;
               end
            end
         end
         OP_REPLACE: begin
            if (right_le) begin
               valid_in = right_valid;
               value_in = right_value;
               tag_in   = right_tag;
            end else if (le || head) begin
               valid_in = x_valid;
               value_in = x_value;
               tag_in   = x_tag;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      tag_ff   <= tag_in;
   end

   assign valid = valid_ff;
   assign value = value_ff;
   assign tag   = tag_ff;

endmodule

`default_nettype wire

### design/k_way_heap_merge.sv
`default_nettype none

// Values are loaded one per cycle while busy is low; the transfer with req_last high closes
// the set and raises busy. The block then reads the head of each non-empty run into a sorted
// chain of cells, one run per cycle, and emits the merged values in ascending order. For each
// result it emits the head cell and reads the next value of its run from the store, then it
// inserts that value into the chain before the next result is emitted. Each result is
// shown on the rsp_ ports for a single cycle with rsp_strobe high and cannot be held off.
// busy falls in the cycle after the result marked rsp_end_of_set. Configuration registers may
// be written only while busy is low.
module k_way_heap_merge import khm_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEFAULT,
   parameter int MAX_RUNS = MAX_RUNS_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic signed [VALUE_W-1:0] req_value,
   input  wire logic                      req_last,
   output logic                           rsp_strobe,
   output logic signed [VALUE_W-1:0]      rsp_merged_value,
   output logic                           rsp_end_of_set,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [CSR_DATA_W-1:0]     csr_data
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int RW = $clog2(MAX_RUNS + 1);
   localparam int TW = 2 * CW;
   localparam int PW = RW + CW;

   state_type state_ff, state_in;

   logic [RUN_COUNT_W-1:0]  run_count_ff;
   logic [RUN_LENGTH_W-1:0] run_length_ff;

   logic [CW-1:0] load_count_ff, load_count_in;
   logic [RW-1:0] rc_ff, rc_in;
   logic [CW-1:0] rl_ff, rl_in;
   logic [CW-1:0] n_ff, n_in;
   logic [CW-1:0] remain_ff, remain_in;
   logic [CW:0]   start_ff, start_in;
   logic [RW-1:0] run_ff, run_in;
   logic          pend_valid_ff, pend_valid_in;
   logic [TW-1:0] pend_tag_ff, pend_tag_in;

   logic [RW-1:0] rc_eff;
   logic [CW-1:0] rl_eff;
   logic [CW-1:0] count_next;
   logic [PW-1:0] total;
   logic [CW-1:0] n_eff;
   logic [CW:0]   build_sum;
   logic [CW-1:0] build_stop;

   logic                      wr_en;
   logic [AW-1:0]             rd_addr;
   logic signed [VALUE_W-1:0] rd_data;

   op_type                    op;
   logic                      x_valid;
   logic signed [VALUE_W-1:0] x_value;
   logic [TW-1:0]             x_tag;

   logic                      cell_valid [MAX_RUNS];
   logic signed [VALUE_W-1:0] cell_value [MAX_RUNS];
   logic [TW-1:0]             cell_tag   [MAX_RUNS];
   logic                      cell_le    [MAX_RUNS];

   logic [CW-1:0] head_pos;
   logic [CW-1:0] head_stop;
   logic [CW-1:0] pos_next;

   always_comb begin
      if (run_count_ff == '0) begin
         rc_eff = RW'(1);
      end else if (int'(run_count_ff) > MAX_RUNS) begin
         rc_eff = RW'(MAX_RUNS);
      end else begin
         rc_eff = RW'(run_count_ff);
      end
      if (run_length_ff == '0) begin
         rl_eff = CW'(1);
      end else if (int'(run_length_ff) > CAPACITY) begin
         rl_eff = CW'(CAPACITY);
      end else begin
         rl_eff = CW'(run_length_ff);
      end
   end

   assign count_next = (load_count_ff < CW'(CAPACITY)) ? load_count_ff + CW'(1) : load_count_ff;
   assign total      = PW'(rc_eff) * PW'(rl_eff);
   assign n_eff      = (PW'(count_next) < total) ? count_next : CW'(total);
   assign build_sum  = start_ff + {1'b0, rl_ff};
   assign build_stop = (build_sum < {1'b0, n_ff}) ? build_sum[CW-1:0] : n_ff;

   assign head_pos  = cell_tag[0][TW-1:CW];
   assign head_stop = cell_tag[0][CW-1:0];
   assign pos_next  = head_pos + CW'(1);

   assign busy             = (state_ff != ST_LOAD);
   assign csr_ready        = 1'b1;
   assign rsp_merged_value = cell_value[0];
   assign x_value          = rd_data;
   assign x_tag            = pend_tag_ff;
   assign x_valid          = pend_valid_ff;

   always_comb begin
      state_in      = state_ff;
      load_count_in = load_count_ff;
      rc_in         = rc_ff;
      rl_in         = rl_ff;
      n_in          = n_ff;
      remain_in     = remain_ff;
      start_in      = start_ff;
      run_in        = run_ff;
      pend_valid_in = pend_valid_ff;
      pend_tag_in   = pend_tag_ff;
      op            = OP_HOLD;
      rd_addr       = '0;
      wr_en         = 1'b0;
      rsp_strobe    = 1'b0;
      rsp_end_of_set = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            if (start) begin
               wr_en         = (load_count_ff < CW'(CAPACITY));
               load_count_in = count_next;
               if (req_last) begin
                  op            = OP_CLEAR;
                  load_count_in = '0;
                  rc_in         = rc_eff;
                  rl_in         = rl_eff;
                  n_in          = n_eff;
                  remain_in     = n_eff;
                  start_in      = '0;
                  run_in        = '0;
                  pend_valid_in = 1'b0;
                  state_in      = ST_BUILD;
               end
            end
         end
         ST_BUILD: begin
            if (pend_valid_ff) begin
               op = OP_INSERT;
            end
            rd_addr = start_ff[AW-1:0];
            if ((run_ff < rc_ff) && (start_ff < {1'b0, n_ff})) begin
               pend_valid_in = 1'b1;
               pend_tag_in   = {start_ff[CW-1:0], build_stop};
               start_in      = build_sum;
               run_in        = run_ff + RW'(1);
            end else begin
               pend_valid_in = 1'b0;
               state_in      = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_strobe     = 1'b1;
            rsp_end_of_set = (remain_ff == CW'(1));
            rd_addr        = pos_next[AW-1:0];
            pend_valid_in  = (pos_next < head_stop);
            pend_tag_in    = {pos_next, head_stop};
            remain_in      = remain_ff - CW'(1);
            state_in       = rsp_end_of_set ? ST_LOAD : ST_FILL;
         end
         ST_FILL: begin
            op       = OP_REPLACE;
            state_in = ST_EMIT;
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         load_count_ff <= '0;
         pend_valid_ff <= 1'b0;
         run_count_ff  <= RUN_COUNT_RESET;
         run_length_ff <= RUN_LENGTH_RESET;
      end else begin
         state_ff      <= state_in;
         load_count_ff <= load_count_in;
         pend_valid_ff <= pend_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_RUN_COUNT: begin
                  run_count_ff <= csr_data[RUN_COUNT_W-1:0];
               end
               CSR_RUN_LENGTH: begin
                  run_length_ff <= csr_data[RUN_LENGTH_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rc_ff       <= rc_in;
      rl_ff       <= rl_in;
      n_ff        <= n_in;
      remain_ff   <= remain_in;
      start_ff    <= start_in;
      run_ff      <= run_in;
      pend_tag_ff <= pend_tag_in;
   end

   khm_store #(
      .CAPACITY(CAPACITY)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(load_count_ff[AW-1:0]),
      .wr_data(req_value),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   for (genvar i = 0; i < MAX_RUNS; i++) begin : g_cell
      logic                      l_valid;
      logic signed [VALUE_W-1:0] l_value;
      logic [TW-1:0]             l_tag;
      logic                      l_le;
      logic                      r_valid;
      logic signed [VALUE_W-1:0] r_value;
      logic [TW-1:0]             r_tag;
      logic                      r_le;

      if (i == 0) begin : g_first
         assign l_valid = 1'b0;
         assign l_value = '0;
         assign l_tag   = '0;
         assign l_le    = 1'b1;
      end else begin : g_inner_left
         assign l_valid = cell_valid[i-1];
         assign l_value = cell_value[i-1];
         assign l_tag   = cell_tag[i-1];
         assign l_le    = cell_le[i-1];
      end

      if (i == MAX_RUNS - 1) begin : g_last
         assign r_valid = 1'b0;
         assign r_value = '0;
         assign r_tag   = '0;
         assign r_le    = 1'b0;
      end else begin : g_inner_right
         assign r_valid = cell_valid[i+1];
         assign r_value = cell_value[i+1];
         assign r_tag   = cell_tag[i+1];
         assign r_le    = cell_le[i+1];
      end

      khm_cell #(
         .TAG_WIDTH(TW)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .op         (op),
         .head       (i == 0),
         .x_valid    (x_valid),
         .x_value    (x_value),
         .x_tag      (x_tag),
         .left_valid (l_valid),
         .left_value (l_value),
         .left_tag   (l_tag),
         .left_le    (l_le),
         .right_valid(r_valid),
         .right_value(r_value),
         .right_tag  (r_tag),
         .right_le   (r_le),
         .valid      (cell_valid[i]),
         .value      (cell_value[i]),
         .tag        (cell_tag[i]),
         .le         (cell_le[i])
      );
   end

`ifndef SYNTHESIS
   a_strobe_head_valid: assert property (
      @(posedge clock) disable iff (reset)
      rsp_strobe |-> cell_valid[0]
   ) else $error("A result was emitted from an empty head cell.");

   a_end_releases_busy: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_end_of_set) |=> !busy
   ) else $error("The block stayed busy after the final result of a set.");

   a_refill_gap: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_end_of_set) |=> !rsp_strobe ##1 rsp_strobe
   ) else $error("Results did not follow the emit and refill sequence.");

   a_last_starts_merge: assert property (
      @(posedge clock) disable iff (reset)
      (start && !busy && req_last) |=> (busy && !rsp_strobe)
   ) else $error("The final transfer of a set did not start the merge.");
`endif

endmodule

`default_nettype wire
